// File: rtl/pzd_pkg.sv
// ----------------------------------------------------------------------------
// Pivot zone detector package
// Shared widths, command and status codes, and the request structs of the
// input and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pzd_pkg;

  // Field widths
  localparam int unsigned IndexBits = 24;
  localparam int unsigned PriceBits = 32;

  // Command codes (the remaining code is a no-op)
  localparam logic [1:0] CmdPushHigh = 2'd0;
  localparam logic [1:0] CmdPushLow  = 2'd1;
  localparam logic [1:0] CmdClear    = 2'd2;

  // Zone direction codes
  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirUp   = 2'd1;
  localparam logic [1:0] DirDown = 2'd2;

  // Exit side codes
  localparam logic [1:0] ExitNone  = 2'd0;
  localparam logic [1:0] ExitAbove = 2'd1;
  localparam logic [1:0] ExitBelow = 2'd2;

  typedef logic [IndexBits-1:0] index_t;
  typedef logic [PriceBits-1:0] price_t;

  // Input request: one swing point or command
  typedef struct packed {
    logic [1:0] command;
    index_t     point_index;
    price_t     point_value;
  } pzd_in_t;

  // Result request: zone status after the point
  typedef struct packed {
    logic       terminated_now;
    logic       zone_valid;
    logic [1:0] zone_direction;
    index_t     zone_start;
    index_t     zone_end;
    price_t     zone_upper;
    price_t     zone_lower;
    logic [1:0] exit_side;
  } pzd_out_t;

endpackage

// File: rtl/pivot_zone_detector_top.sv
// ----------------------------------------------------------------------------
// Pivot zone detector
// Tracks the three newest swing highs and lows, forms an overlap zone when
// the oldest point trends into a non-empty band, then extends the zone end
// and flags a breakout above or below the band.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) takes one request per
//   cycle while in_stall_o is low: push high, push low or clear. Result
//   channel (out_valid_o / out_stall_i / out_req_o) returns exactly one
//   request per input request. An accepted request passes the input register,
//   then the update logic writes the zone state and the result register.
//   Throughput is one request per cycle while out_stall_i holds no result,
//   set by the state update on the registered point.
//   While out_stall_i holds a result, one more request is taken into the
//   input register; after that in_stall_o rises until the result leaves.
//   Reset clears all point history and zone state and empties both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pivot_zone_detector_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pzd_pkg::pzd_in_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pzd_pkg::pzd_out_t  out_req_o
);
  import pzd_pkg::*;

  // Pipeline control
  logic     s1_valid_q;
  pzd_in_t  s1_req_q;
  logic     out_valid_q;
  pzd_out_t out_req_q;
  logic     s2_ready;
  logic     s1_advance;
  logic     in_accept;

  // Point history, entry 0 newest
  index_t hi_idx_q [3];
  price_t hi_prc_q [3];
  index_t lo_idx_q [3];
  price_t lo_prc_q [3];
  index_t hi_idx_d [3];
  price_t hi_prc_d [3];
  index_t lo_idx_d [3];
  price_t lo_prc_d [3];

  // Zone state
  logic       zone_flag_q, zone_flag_d;
  index_t     zone_begin_q, zone_begin_d;
  index_t     zone_finish_q, zone_finish_d;
  price_t     band_top_q, band_top_d;
  price_t     band_bottom_q, band_bottom_d;
  logic [1:0] zone_trend_q, zone_trend_d;
  logic [1:0] breakout_q, breakout_d;
  logic       term_d;

  // Candidate band from the updated history
  price_t cand_top;
  price_t cand_bottom;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Shift the pushed point into its history, or clear all history
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hi_idx_d[k] = hi_idx_q[k];
      hi_prc_d[k] = hi_prc_q[k];
      lo_idx_d[k] = lo_idx_q[k];
      lo_prc_d[k] = lo_prc_q[k];
    end
    case (s1_req_q.command)
      CmdPushHigh: begin
        hi_idx_d[2] = hi_idx_q[1];
        hi_prc_d[2] = hi_prc_q[1];
        hi_idx_d[1] = hi_idx_q[0];
        hi_prc_d[1] = hi_prc_q[0];
        hi_idx_d[0] = s1_req_q.point_index;
        hi_prc_d[0] = s1_req_q.point_value;
      end
      CmdPushLow: begin
        lo_idx_d[2] = lo_idx_q[1];
        lo_prc_d[2] = lo_prc_q[1];
        lo_idx_d[1] = lo_idx_q[0];
        lo_prc_d[1] = lo_prc_q[0];
        lo_idx_d[0] = s1_req_q.point_index;
        lo_prc_d[0] = s1_req_q.point_value;
      end
      CmdClear: begin
        for (int k = 0; k < 3; k++) begin
          hi_idx_d[k] = '0;
          hi_prc_d[k] = '0;
          lo_idx_d[k] = '0;
          lo_prc_d[k] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign cand_top    = (hi_prc_d[0] < hi_prc_d[1]) ? hi_prc_d[0] : hi_prc_d[1];
  assign cand_bottom = (lo_prc_d[0] > lo_prc_d[1]) ? lo_prc_d[0] : lo_prc_d[1];

  // Form, extend, break or clear the zone
  always_comb begin
    zone_flag_d   = zone_flag_q;
    zone_begin_d  = zone_begin_q;
    zone_finish_d = zone_finish_q;
    band_top_d    = band_top_q;
    band_bottom_d = band_bottom_q;
    zone_trend_d  = zone_trend_q;
    breakout_d    = breakout_q;
    term_d        = 1'b0;
    case (s1_req_q.command)
      CmdPushHigh: begin
        if (zone_flag_q) begin
          if (hi_prc_d[0] < band_bottom_q) begin
            breakout_d = ExitBelow;
            term_d     = 1'b1;
            if (hi_idx_d[1] > zone_finish_q) zone_finish_d = hi_idx_d[1];
          end else if (lo_idx_d[0] > zone_finish_q) begin
            zone_finish_d = lo_idx_d[0];
          end
        end else if ((hi_idx_d[2] != '0) && (hi_idx_d[1] != '0) && (hi_idx_d[0] != '0)
                     && (lo_idx_d[1] != '0) && (lo_idx_d[0] != '0)
                     && (hi_prc_d[2] > hi_prc_d[1]) && (cand_top > cand_bottom)) begin
          zone_trend_d  = DirDown;
          zone_begin_d  = lo_idx_d[1];
          zone_finish_d = hi_idx_d[0];
          band_top_d    = cand_top;
          band_bottom_d = cand_bottom;
          zone_flag_d   = 1'b1;
        end
      end
      CmdPushLow: begin
        if (zone_flag_q) begin
          if (lo_prc_d[0] > band_top_q) begin
            breakout_d = ExitAbove;
            term_d     = 1'b1;
            if (lo_idx_d[1] > zone_finish_q) zone_finish_d = lo_idx_d[1];
          end else if (hi_idx_d[0] > zone_finish_q) begin
            zone_finish_d = hi_idx_d[0];
          end
        end else if ((hi_idx_d[1] != '0) && (hi_idx_d[0] != '0) && (lo_idx_d[2] != '0)
                     && (lo_idx_d[1] != '0) && (lo_idx_d[0] != '0)
                     && (lo_prc_d[2] < lo_prc_d[1]) && (cand_top > cand_bottom)) begin
          zone_trend_d  = DirUp;
          zone_begin_d  = hi_idx_d[1];
          zone_finish_d = lo_idx_d[0];
          band_top_d    = cand_top;
          band_bottom_d = cand_bottom;
          zone_flag_d   = 1'b1;
        end
      end
      CmdClear: begin
        zone_flag_d   = 1'b0;
        zone_begin_d  = '0;
        zone_finish_d = '0;
        band_top_d    = '0;
        band_bottom_d = '0;
        zone_trend_d  = DirNone;
        breakout_d    = ExitNone;
      end
      default: begin
      end
    endcase
  end

  // Hold control state and point history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      zone_flag_q   <= 1'b0;
      zone_begin_q  <= '0;
      zone_finish_q <= '0;
      band_top_q    <= '0;
      band_bottom_q <= '0;
      zone_trend_q  <= DirNone;
      breakout_q    <= ExitNone;
      for (int k = 0; k < 3; k++) begin
        hi_idx_q[k] <= '0;
        hi_prc_q[k] <= '0;
        lo_idx_q[k] <= '0;
        lo_prc_q[k] <= '0;
      end
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        zone_flag_q   <= zone_flag_d;
        zone_begin_q  <= zone_begin_d;
        zone_finish_q <= zone_finish_d;
        band_top_q    <= band_top_d;
        band_bottom_q <= band_bottom_d;
        zone_trend_q  <= zone_trend_d;
        breakout_q    <= breakout_d;
        for (int k = 0; k < 3; k++) begin
          hi_idx_q[k] <= hi_idx_d[k];
          hi_prc_q[k] <= hi_prc_d[k];
          lo_idx_q[k] <= lo_idx_d[k];
          lo_prc_q[k] <= lo_prc_d[k];
        end
      end
    end
  end

  // Capture the input request and the result request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= in_req_i;
    end
    if (s1_advance) begin
      out_req_q.terminated_now <= term_d;
      out_req_q.zone_valid     <= zone_flag_d;
      out_req_q.zone_direction <= zone_trend_d;
      out_req_q.zone_start     <= zone_begin_d;
      out_req_q.zone_end       <= zone_finish_d;
      out_req_q.zone_upper     <= band_top_d;
      out_req_q.zone_lower     <= band_bottom_d;
      out_req_q.exit_side      <= breakout_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

`ifndef NO_ASSERTIONS
  // A breakout result always reports a live zone with an exit side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.terminated_now |->
      out_req_o.zone_valid && (out_req_o.exit_side != ExitNone))
    else $error("breakout reported without a zone or exit side");

  // A formed zone carries a direction and a non-empty band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zone_flag_q |-> (zone_trend_q != DirNone) && (band_top_q > band_bottom_q))
    else $error("zone formed without direction or with empty band");

  // Input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result stage can drain");

  // An exit side is only recorded inside a zone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (breakout_q != ExitNone) |-> zone_flag_q)
    else $error("exit side set without a zone");
`endif

endmodule

// File: tb/sv/pzd_zone_checker.sv
// ----------------------------------------------------------------------------
// Pivot zone result checker
// Watches both request channels of the pivot zone detector, predicts the zone
// status for every accepted point and compares each accepted result, field by
// field, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pzd_zone_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pzd_pkg::pzd_in_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  pzd_pkg::pzd_out_t out_req_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_count_o
);
  import pzd_pkg::*;

  localparam int unsigned ReportLimit = 200;

  // Predicted swing history, entry 0 newest
  index_t     hi_idx [3];
  price_t     hi_prc [3];
  index_t     lo_idx [3];
  price_t     lo_prc [3];

  // Predicted zone
  logic       zone_on;
  index_t     zone_first;
  index_t     zone_last;
  price_t     band_hi;
  price_t     band_lo;
  logic [1:0] trend;
  logic [1:0] exit_dir;

  pzd_out_t    zone_expected_q [$];
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  task automatic clear_history();
    for (int k = 0; k < 3; k++) begin
      hi_idx[k] = '0;
      hi_prc[k] = '0;
      lo_idx[k] = '0;
      lo_prc[k] = '0;
    end
    zone_on    = 1'b0;
    zone_first = '0;
    zone_last  = '0;
    band_hi    = '0;
    band_lo    = '0;
    trend      = DirNone;
    exit_dir   = ExitNone;
  endtask

  function automatic index_t later_index(index_t a, index_t b);
    return (b > a) ? b : a;
  endfunction

  // Advance the predicted state by one point and build the expected result
  task automatic predict_zone(input pzd_in_t req, output pzd_out_t res);
    logic   broke;
    price_t top_c;
    price_t bot_c;
    broke = 1'b0;
    if (req.command == CmdPushHigh) begin
      hi_idx[2] = hi_idx[1];
      hi_prc[2] = hi_prc[1];
      hi_idx[1] = hi_idx[0];
      hi_prc[1] = hi_prc[0];
      hi_idx[0] = req.point_index;
      hi_prc[0] = req.point_value;
    end else if (req.command == CmdPushLow) begin
      lo_idx[2] = lo_idx[1];
      lo_prc[2] = lo_prc[1];
      lo_idx[1] = lo_idx[0];
      lo_prc[1] = lo_prc[0];
      lo_idx[0] = req.point_index;
      lo_prc[0] = req.point_value;
    end else if (req.command == CmdClear) begin
      clear_history();
    end

    // Candidate band: lower of the two newest highs over higher of two lows
    top_c = (hi_prc[0] < hi_prc[1]) ? hi_prc[0] : hi_prc[1];
    bot_c = (lo_prc[0] > lo_prc[1]) ? lo_prc[0] : lo_prc[1];

    if (req.command == CmdPushHigh) begin
      if (zone_on) begin
        if (hi_prc[0] < band_lo) begin
          exit_dir  = ExitBelow;
          zone_last = later_index(zone_last, hi_idx[1]);
          broke     = 1'b1;
        end else begin
          zone_last = later_index(zone_last, lo_idx[0]);
        end
      end else if (hi_idx[2] != 0 && hi_idx[1] != 0 && hi_idx[0] != 0 &&
                   lo_idx[1] != 0 && lo_idx[0] != 0 &&
                   hi_prc[2] > hi_prc[1] && top_c > bot_c) begin
        zone_on    = 1'b1;
        trend      = DirDown;
        zone_first = lo_idx[1];
        zone_last  = hi_idx[0];
        band_hi    = top_c;
        band_lo    = bot_c;
      end
    end else if (req.command == CmdPushLow) begin
      if (zone_on) begin
        if (lo_prc[0] > band_hi) begin
          exit_dir  = ExitAbove;
          zone_last = later_index(zone_last, lo_idx[1]);
          broke     = 1'b1;
        end else begin
          zone_last = later_index(zone_last, hi_idx[0]);
        end
      end else if (hi_idx[1] != 0 && hi_idx[0] != 0 && lo_idx[2] != 0 &&
                   lo_idx[1] != 0 && lo_idx[0] != 0 &&
                   lo_prc[2] < lo_prc[1] && top_c > bot_c) begin
        zone_on    = 1'b1;
        trend      = DirUp;
        zone_first = hi_idx[1];
        zone_last  = lo_idx[0];
        band_hi    = top_c;
        band_lo    = bot_c;
      end
    end

    res.terminated_now = broke;
    res.zone_valid     = zone_on;
    res.zone_direction = trend;
    res.zone_start     = zone_first;
    res.zone_end       = zone_last;
    res.zone_upper     = band_hi;
    res.zone_lower     = band_lo;
    res.exit_side      = exit_dir;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < ReportLimit) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Retire results before taking new points: a result never belongs to a
  // point accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    pzd_out_t want;
    if (!rst_ni) begin
      clear_history();
      zone_expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (zone_expected_q.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("%0t: no result expected, actual 0x%0h", $time, out_req_i);
          end
          mismatches++;
        end else begin
          want = zone_expected_q.pop_front();
          check_field("terminated_now", 32'(want.terminated_now),
                      32'(out_req_i.terminated_now));
          check_field("zone_valid", 32'(want.zone_valid), 32'(out_req_i.zone_valid));
          check_field("zone_direction", 32'(want.zone_direction),
                      32'(out_req_i.zone_direction));
          check_field("zone_start", 32'(want.zone_start), 32'(out_req_i.zone_start));
          check_field("zone_end", 32'(want.zone_end), 32'(out_req_i.zone_end));
          check_field("zone_upper", 32'(want.zone_upper), 32'(out_req_i.zone_upper));
          check_field("zone_lower", 32'(want.zone_lower), 32'(out_req_i.zone_lower));
          check_field("exit_side", 32'(want.exit_side), 32'(out_req_i.exit_side));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_zone(in_req_i, want);
        zone_expected_q.push_back(want);
      end
    end
    pending = zone_expected_q.size();
  end

endmodule

// File: tb/sv/tb_pivot_zone_detector_top.sv
// ----------------------------------------------------------------------------
// Pivot zone detector testbench
// Drives directed swing sequences (zone forming up and down, extension,
// breakouts on both sides, clear, unused command, field extremes) and then
// randomized swing runs mixed with noise, under several idle and stall
// patterns. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pivot_zone_detector_top;
  import pzd_pkg::*;

  localparam logic [1:0]  CmdNop       = 2'd3;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 482;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pzd_in_t     in_req    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pzd_out_t    out_req;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches;
  int unsigned pending;

  always #2 clk = ~clk;

  pivot_zone_detector_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  pzd_zone_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_req_i        (out_req),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // Drop the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall, or a long hold when one is asked for
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Offer one request after a random idle gap and hold it until taken
  task automatic send_point(input logic [1:0] cmd, input index_t idx, input price_t prc);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{command: cmd, point_index: idx, point_value: prc};
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Swing runs around a random base price, with noise points mixed in
  task automatic send_random(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    price_t      base;
    price_t      span;
    price_t      offset;
    index_t      bar;
    index_t      idx;
    logic [1:0]  cmd;
    sent = 0;
    cmd  = CmdPushLow;
    while (sent < count) begin
      // start a run, usually from a cleared history
      if ($urandom_range(9) < 8) begin
        send_point(CmdClear, index_t'($urandom), $urandom);
        sent++;
      end
      base = $urandom;
      span = price_t'($urandom_range(16, 4096)) << $urandom_range(0, 16);
      bar  = index_t'($urandom_range(1, 1 << 20));
      len  = $urandom_range(4, 24);
      repeat (len) begin
        if ($urandom_range(9) == 0) begin
          cmd = 2'($urandom_range(3));
          send_point(cmd, index_t'($urandom), $urandom);
          if (cmd != CmdNop) sent++;
        end else begin
          // mostly alternate highs and lows; highs sit between base - span/4 and base + 3*span/4
          if ($urandom_range(4) == 0) begin
            cmd = $urandom_range(1) ? CmdPushHigh : CmdPushLow;
          end else begin
            cmd = (cmd == CmdPushHigh) ? CmdPushLow : CmdPushHigh;
          end
          bar    = bar + index_t'($urandom_range(0, 8));
          idx    = ($urandom_range(19) == 0) ? '0 : bar;
          offset = price_t'($urandom_range(0, span));
          if (cmd == CmdPushHigh) begin
            send_point(cmd, idx, base + offset - (span >> 2));
          end else begin
            send_point(cmd, idx, base - offset + (span >> 2));
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, unused command
    send_point(CmdPushHigh, '1, '1);
    send_point(CmdPushLow, '0, '0);
    send_point(CmdNop, '1, '1);
    send_point(CmdPushLow, '1, '1);
    send_point(CmdPushHigh, '0, '0);
    send_point(CmdClear, '1, '1);

    // Down zone: forms on a high, extends, touches the band, breaks both ways
    send_point(CmdPushHigh, 10, 500);
    send_point(CmdPushLow, 11, 100);
    send_point(CmdPushHigh, 12, 400);
    send_point(CmdPushLow, 13, 150);
    send_point(CmdPushHigh, 14, 450);
    send_point(CmdPushLow, 15, 200);
    send_point(CmdPushLow, 16, 400);
    send_point(CmdPushHigh, 17, 150);
    send_point(CmdPushHigh, 18, 100);
    send_point(CmdPushLow, 19, 900);
    send_point(CmdClear, 0, 0);

    // Up zone: forms on a low, then breaks below
    send_point(CmdPushLow, 20, 100);
    send_point(CmdPushHigh, 21, 500);
    send_point(CmdPushLow, 22, 200);
    send_point(CmdPushHigh, 23, 480);
    send_point(CmdPushLow, 24, 150);
    send_point(CmdPushHigh, 25, 10);
    wait_drained();

    // Full rate, with one long hold on the result side
    holds_asked++;
    send_random(PhaseItems);
    wait_drained();

    in_idle_pct = 87;
    send_random(PhaseItems);
    wait_drained();

    in_idle_pct   = 0;
    out_stall_pct = 87;
    send_random(PhaseItems);
    wait_drained();

    in_idle_pct   = 20;
    out_stall_pct = 20;
    holds_asked++;
    send_random(PhaseItems);
    wait_drained();

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
